### hw/rtl/char_lcd_cursor_writer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the character display cursor writer
// Each check comes in a simulation form and an empty synthesis form.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_CURSOR_WRITER_CORE_MACROS_SVH
`define CHAR_LCD_CURSOR_WRITER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define CLCW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("clcw check failed");

// next-cycle implication, checked outside reset
`define CLCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("clcw check failed");

`else

`define CLCW_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define CLCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/clcw_pkg.sv
// ----------------------------------------------------------------------------
// clcw_pkg
// Types and constants shared by the cursor writer front, queue and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clcw_pkg;

    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int ROW_W  = 2;
    localparam int CFG_W  = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GOTO  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // register indexes
    localparam logic [CFG_W-1:0] CFG_ROW0 = 2'd0;
    localparam logic [CFG_W-1:0] CFG_ROW1 = 2'd1;
    localparam logic [CFG_W-1:0] CFG_ROW2 = 2'd2;
    localparam logic [CFG_W-1:0] CFG_ROW3 = 2'd3;

    localparam logic [BYTE_W-1:0] ROW0_RESET = 8'd128;
    localparam logic [BYTE_W-1:0] ROW1_RESET = 8'd192;
    localparam logic [BYTE_W-1:0] ROW2_RESET = 8'd144;
    localparam logic [BYTE_W-1:0] ROW3_RESET = 8'd208;

    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [BYTE_W-1:0] IGNORED_CODE = 8'd4;
    localparam logic [BYTE_W-1:0] PRINT_LOW    = 8'd32;
    localparam logic [BYTE_W-1:0] PRINT_HIGH   = 8'd128;
    localparam logic [BYTE_W-1:0] CLEAR_INSTR  = 8'h01;
    localparam logic [ROW_W-1:0]  MAX_ROW      = 2'h3;

    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    typedef enum logic [1:0] {
        OP_NEWLINE,
        OP_PRINT,
        OP_GOTO,
        OP_CLEAR
    } t_op_kind;

    // classified item: data is the character code or the masked column
    typedef struct packed {
        t_op_kind          kind;
        logic [BYTE_W-1:0] data;
        logic [ROW_W-1:0]  row;
    } t_op;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

endpackage

### hw/rtl/char_lcd_cursor_writer_core.sv
// ----------------------------------------------------------------------------
// char_lcd_cursor_writer_core
// Turns display commands into instruction and data byte writes for a
// four-row character display, tracking the cursor column and row.
//
//   channel   direction  handshake                payload
//   in        to core    i_in_valid / o_in_stall  i_command i_char_code i_column i_row
//   out       from core  o_out_valid / i_out_stall o_register_select o_byte_out
//                                                 o_last_of_run
//   cfg       to core    i_cfg_we                 i_cfg_index i_cfg_data
//
// One beat per cycle in and out while the queue is not full and the output is not
// stalled; a print that wraps to the next row costs the back end a set-address
// beat, then the data byte, everything else one beat.
// Synchronous active-low reset clears the cursor, the queue and the output valid.
// The input stalls only when the two-entry queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "char_lcd_cursor_writer_core_macros.svh"

module char_lcd_cursor_writer_core
    import clcw_pkg::*;
#(
    parameter int COLUMN_MASK = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_index,
    input  logic [BYTE_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [BYTE_W-1:0] i_char_code,
    input  logic [BYTE_W-1:0] i_column,
    input  logic [BYTE_W-1:0] i_row,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_register_select,
    output logic [BYTE_W-1:0] o_byte_out,
    output logic              o_last_of_run
);

    t_q_status q_status;
    t_op       push_op;
    t_op       head;
    logic      push;
    logic      pop;

    clcw_front #(
        .COLUMN_MASK (COLUMN_MASK)
    ) u_front (
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_char_code (i_char_code),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_op   (push_op)
    );

    clcw_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (push_op),
        .i_pop     (pop),
        .o_head    (head),
        .o_status  (q_status)
    );

    clcw_back #(
        .COLUMN_MASK (COLUMN_MASK)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_head            (head),
        .i_q_status        (q_status),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_register_select (o_register_select),
        .o_byte_out        (o_byte_out),
        .o_last_of_run     (o_last_of_run)
    );

    // a wrap set-address, once taken, is followed at once by its data byte
    `CLCW_ASSERT_NEXT(a_wrap_then_data, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_last_of_run, o_out_valid && o_register_select && o_last_of_run)
    // only instruction beats are ever non-final
    `CLCW_ASSERT_NOW(a_mid_is_instr, i_clk, i_rst_n, o_out_valid && !o_last_of_run, !o_register_select)
    // a stalled input means the queue holds work
    `CLCW_ASSERT_NOW(a_stall_has_work, i_clk, i_rst_n, o_in_stall, q_status.not_empty)
    // nothing is popped from an empty queue
    `CLCW_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, pop, q_status.not_empty)

endmodule

### hw/rtl/clcw_front.sv
// ----------------------------------------------------------------------------
// clcw_front
// Accepts command beats, drops those that write nothing and classifies the
// rest into queue entries with the goto column masked and row saturated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clcw_front
    import clcw_pkg::*;
#(
    parameter int COLUMN_MASK = 15
) (
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [BYTE_W-1:0] i_char_code,
    input  logic [BYTE_W-1:0] i_column,
    input  logic [BYTE_W-1:0] i_row,
    input  t_q_status         i_q_status,
    output logic              o_push,
    output t_op               o_push_op
);

    logic accept;
    logic keep;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;
    assign o_push     = accept && keep;

    always_comb begin
        keep           = 1'b0;
        o_push_op.kind = OP_PRINT;
        o_push_op.data = i_char_code;
        o_push_op.row  = (i_row > BYTE_W'(MAX_ROW)) ? MAX_ROW : i_row[ROW_W-1:0];
        unique case (i_command)
            CMD_PUT: begin
                if (i_char_code == NEWLINE_CODE) begin
                    keep           = 1'b1;
                    o_push_op.kind = OP_NEWLINE;
                end else if (i_char_code != IGNORED_CODE
                             && i_char_code >= PRINT_LOW
                             && i_char_code <= PRINT_HIGH) begin
                    keep           = 1'b1;
                    o_push_op.kind = OP_PRINT;
                end
            end
            CMD_GOTO: begin
                keep           = 1'b1;
                o_push_op.kind = OP_GOTO;
                o_push_op.data = i_column & BYTE_W'(COLUMN_MASK);
            end
            CMD_CLEAR: begin
                keep           = 1'b1;
                o_push_op.kind = OP_CLEAR;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/clcw_queue.sv
// ----------------------------------------------------------------------------
// clcw_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clcw_queue
    import clcw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_op       i_push_op,
    input  logic      i_pop,
    output t_op       o_head,
    output t_q_status o_status
);

    t_op        r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_head            = r_mem[r_rd_ptr];
    assign o_status.not_empty = (r_count != 2'd0);
    assign o_status.full      = (r_count == 2'd2);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

endmodule

### hw/rtl/clcw_back.sv
// ----------------------------------------------------------------------------
// clcw_back
// Holds the cursor and row address registers, carries out queued items and
// drives the registered write output. A print past the last column gives the
// wrap set-address first, then the data byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clcw_back
    import clcw_pkg::*;
#(
    parameter int COLUMN_MASK = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_index,
    input  logic [BYTE_W-1:0] i_cfg_data,
    input  t_op               i_head,
    input  t_q_status         i_q_status,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_register_select,
    output logic [BYTE_W-1:0] o_byte_out,
    output logic              o_last_of_run
);

    localparam int COL_W = $clog2(COLUMN_MASK + 2);

    logic [BYTE_W-1:0] r_row_addr [4];
    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  n_row;
    logic              r_out_valid;
    logic              r_rs;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              n_rs;
    logic [BYTE_W-1:0] n_byte;
    logic              n_last;
    logic              out_free;
    logic              load;
    logic              wrap;
    logic [BYTE_W-1:0] set_addr;

    assign o_out_valid       = r_out_valid;
    assign o_register_select = r_rs;
    assign o_byte_out        = r_byte;
    assign o_last_of_run     = r_last;

    assign out_free = !r_out_valid || !i_out_stall;
    assign load     = i_q_status.not_empty && out_free;
    assign wrap     = r_col > COL_W'(COLUMN_MASK);
    // one read of the row table, at the row the cursor lands on
    assign set_addr = r_row_addr[n_row] | BYTE_W'(n_col);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_rs  = RS_INSTR;
        n_last = 1'b1;
        o_pop = 1'b0;
        unique case (i_head.kind)
            OP_NEWLINE: begin
                n_col = '0;
                n_row = r_row + 2'd1;
                o_pop = load;
            end
            OP_PRINT: begin
                if (wrap) begin
                    // wrap first, keep the item for the data byte
                    n_col  = '0;
                    n_row  = r_row + 2'd1;
                    n_last = 1'b0;
                end else begin
                    n_col = r_col + COL_W'(1);
                    n_rs  = RS_DATA;
                    o_pop = load;
                end
            end
            OP_GOTO: begin
                n_col = i_head.data[COL_W-1:0];
                n_row = i_head.row;
                o_pop = load;
            end
            OP_CLEAR: begin
                n_col = '0;
                n_row = '0;
                o_pop = load;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        priority if (i_head.kind == OP_CLEAR) begin
            n_byte = CLEAR_INSTR;
        end else if (i_head.kind == OP_PRINT && !wrap) begin
            n_byte = i_head.data;
        end else begin
            n_byte = set_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_row         <= '0;
            r_out_valid   <= 1'b0;
            r_row_addr[0] <= ROW0_RESET;
            r_row_addr[1] <= ROW1_RESET;
            r_row_addr[2] <= ROW2_RESET;
            r_row_addr[3] <= ROW3_RESET;
        end else begin
            if (load) begin
                r_col       <= n_col;
                r_row       <= n_row;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ROW0: r_row_addr[0] <= i_cfg_data;
                    CFG_ROW1: r_row_addr[1] <= i_cfg_data;
                    CFG_ROW2: r_row_addr[2] <= i_cfg_data;
                    CFG_ROW3: r_row_addr[3] <= i_cfg_data;
                    default:  r_row_addr[0] <= r_row_addr[0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rs   <= n_rs;
            r_byte <= n_byte;
            r_last <= n_last;
        end
    end

endmodule
